// File: rtl/core/mbd_pkg.sv
// Shared constants and types for the mask box dilation block.
package mbd_pkg;

    localparam int MAX_WIDTH  = 2048;
    localparam int MAX_RADIUS = 16;

    localparam int HCELLS     = 2 * MAX_RADIUS + 1;   // raw pixel window
    localparam int VCELLS     = 2 * MAX_RADIUS;       // delayed row taps
    localparam int LINE_DEPTH = MAX_WIDTH - 1;        // each tap adds one register

    localparam int PIX_W  = 8;
    localparam int XW     = $clog2(MAX_WIDTH + 1);
    localparam int RW     = $clog2(MAX_RADIUS + 1);
    localparam int TW     = $clog2(HCELLS + 1);
    localparam int PTR_W  = $clog2(LINE_DEPTH);
    localparam int HW     = 16;
    localparam int YW     = HW + 1;
    localparam int CFG_W  = 16;
    localparam int IDX_W  = 2;

    typedef logic [IDX_W-1:0] reg_idx_t;

    localparam reg_idx_t REG_RADIUS = 2'd0;
    localparam reg_idx_t REG_WIDTH  = 2'd1;
    localparam reg_idx_t REG_HEIGHT = 2'd2;

    // horizontal clip info for the pixel under evaluation
    typedef struct packed {
        logic [XW-1:0] x;     // column of the center pixel
        logic [XW-1:0] rem;   // columns left to its right in the row
        logic [RW-1:0] rad;   // effective radius
    } hwin_t;

    // vertical clip: taps lo..hi take part
    typedef struct packed {
        logic [TW-1:0] lo;
        logic [TW-1:0] hi;
    } vwin_t;

endpackage

// File: rtl/core/mbd_hcell.sv
// One stage of the raw pixel shift chain with its horizontal clip gate.
module mbd_hcell
    import mbd_pkg::*;
(
    input  logic             clk,
    input  logic             shift,
    input  logic [PIX_W-1:0] din,
    input  logic [TW-1:0]    idx,
    input  hwin_t            win,
    output logic [PIX_W-1:0] dout,
    output logic [PIX_W-1:0] gated
);

    logic [PIX_W-1:0] pix_reg;
    logic [TW-1:0]    rad6;
    logic [TW-1:0]    hop;
    logic             in_span;
    logic             in_row;

    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            pix_reg <= din;
        end
    end

    // idx <= r: pixel right of center by r-idx; else left by idx-r
    always_comb
    begin
        rad6    = TW'(win.rad);
        in_span = idx <= (rad6 << 1);
        if (idx <= rad6)
        begin
            hop    = rad6 - idx;
            in_row = XW'(hop) <= win.rem;
        end
        else
        begin
            hop    = idx - rad6;
            in_row = XW'(hop) <= win.x;
        end
    end

    assign dout  = pix_reg;
    assign gated = (in_span && in_row) ? pix_reg : '0;

endmodule

// File: rtl/core/mbd_vcell.sv
// One row-delay cell: line memory plus output tap, delay of one frame row.
module mbd_vcell
    import mbd_pkg::*;
(
    input  logic             clk,
    input  logic             adv,
    input  logic             bypass,
    input  logic [PTR_W-1:0] ptr,
    input  logic [PIX_W-1:0] din,
    input  logic [TW-1:0]    idx,
    input  vwin_t            win,
    output logic [PIX_W-1:0] dout,
    output logic [PIX_W-1:0] gated
);

    logic [PIX_W-1:0] mem [LINE_DEPTH];
    logic [PIX_W-1:0] tap_reg;

    // width-1 entries in memory + tap register = one row of delay
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            if (!bypass)
            begin
                mem[ptr] <= din;
            end
            tap_reg <= bypass ? din : mem[ptr];
        end
    end

    assign dout  = tap_reg;
    assign gated = (idx >= win.lo && idx <= win.hi) ? tap_reg : '0;

endmodule

// File: rtl/core/mask_box_dilation.sv
// Top level of the streaming square OR-dilation of an 8-bit flag mask.
//
// Pixels enter in raster order and each result is the bitwise OR of the
// flags in the square window of the programmed radius, clipped at the frame
// edges; a radius of zero passes the mask through. The block takes one
// request per clock while the output is not stalled and holds a three-stage
// pipe: a chain of 33 pixel cells builds the horizontal OR, a chain of 32
// row-delay cells (each a 2047-entry line memory plus a tap register) holds
// the rows above, and an output register drives the result channel. The
// result for pixel k leaves with request k + radius*width + radius; after
// the frame the host sends exactly that many drain requests to flush. A
// drain request at frame start is dropped, and a pixel request past the
// frame counts as a drain. Line memories are not cleared: entries are only
// used after the current frame wrote them, so no clearing pass runs after
// reset. Any register write must be made while the block is idle; a write
// to the radius, width or height register restarts the frame. in_stall
// rises only while the output register holds a result that the sink stalls.
module mask_box_dilation
    import mbd_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  reg_idx_t         cfg_idx,
    input  logic [CFG_W-1:0] cfg_data,
    input  logic             in_valid,
    output logic             in_stall,
    input  logic [PIX_W-1:0] mask_in,
    input  logic             drain,
    output logic             out_valid,
    input  logic             out_stall,
    output logic [PIX_W-1:0] mask_out,
    output logic             frame_last
);

    // configuration
    logic [RW-1:0]    radius_reg;
    logic [XW-1:0]    width_reg;
    logic [HW-1:0]    height_reg;
    logic [RW-1:0]    r_eff;
    logic [XW-1:0]    w_eff;
    logic [HW-1:0]    h_eff;
    logic [XW-1:0]    w_last;
    logic [HW-1:0]    h_last;

    // position counters: input pixel (ix,iy), center pixel m (mx,my)
    logic [XW-1:0]    ix_reg;
    logic [HW-1:0]    iy_reg;
    logic [RW-1:0]    lead_reg;
    logic [XW-1:0]    mx_reg;
    logic [YW-1:0]    my_reg;
    logic [PTR_W-1:0] ptr_reg;

    // stage 2: horizontal OR
    logic             s2_vld_reg;
    logic             s2_out_reg;
    logic             s2_last_reg;
    logic [XW-1:0]    s2_x_reg;
    logic [YW-1:0]    s2_y_reg;

    // stage 3: vertical OR
    logic [PIX_W-1:0] hor_reg;
    logic             s3_out_reg;
    logic             s3_last_reg;
    vwin_t            s3_win_reg;

    // output register
    logic             out_valid_reg;
    logic [PIX_W-1:0] mask_out_reg;
    logic             frame_last_reg;

    logic             go;
    logic             take;
    logic             first;
    logic             in_frame;
    logic             m_on;
    logic             last_now;
    logic             produce;
    logic             cfg_hit;
    logic             adv;
    logic             bypass;
    logic [PIX_W-1:0] pix_new;
    logic [PIX_W-1:0] hor_or;
    logic [PIX_W-1:0] ver_or;
    logic [TW-1:0]    two_r;
    logic [YW-1:0]    lo_diff;
    hwin_t            hwin;
    vwin_t            vwin;

    logic [PIX_W-1:0] hchain [HCELLS+1];
    logic [PIX_W-1:0] hgated [HCELLS];
    logic [PIX_W-1:0] vchain [VCELLS+1];
    logic [PIX_W-1:0] vgated [VCELLS];

    // clamp register values to the supported range
    always_comb
    begin
        r_eff = (radius_reg > RW'(MAX_RADIUS)) ? RW'(MAX_RADIUS) : radius_reg;
        if (width_reg == '0)
        begin
            w_eff = XW'(1);
        end
        else if (width_reg > XW'(MAX_WIDTH))
        begin
            w_eff = XW'(MAX_WIDTH);
        end
        else
        begin
            w_eff = width_reg;
        end
        h_eff  = (height_reg == '0) ? HW'(1) : height_reg;
        w_last = w_eff - XW'(1);
        h_last = h_eff - HW'(1);
    end

    // whole pipe moves together; only a stalled full output stops it
    assign go       = !(out_valid_reg && out_stall);
    assign in_stall = !go;

    always_comb
    begin
        first    = (ix_reg == '0) && (iy_reg == '0);
        take     = in_valid && go && !(first && drain);
        in_frame = iy_reg < h_eff;
        pix_new  = (drain || !in_frame) ? '0 : mask_in;
        m_on     = lead_reg == r_eff;
        last_now = m_on && (mx_reg == w_last) && (my_reg == YW'(h_last) + YW'(r_eff));
        produce  = m_on && (my_reg >= YW'(r_eff)) && (my_reg < YW'(h_eff) + YW'(r_eff));
        cfg_hit  = 1'b0;
        if (cfg_we)
        begin
            case (cfg_idx)
                REG_RADIUS: cfg_hit = 1'b1;
                REG_WIDTH:  cfg_hit = 1'b1;
                REG_HEIGHT: cfg_hit = 1'b1;
                default:    cfg_hit = 1'b0;
            endcase
        end
    end

    // config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg <= RW'(1);
            width_reg  <= XW'(MAX_WIDTH);
            height_reg <= HW'(2048);
        end
        else if (cfg_we)
        begin
            case (cfg_idx)
                REG_RADIUS: radius_reg <= cfg_data[RW-1:0];
                REG_WIDTH:  width_reg  <= cfg_data[XW-1:0];
                REG_HEIGHT: height_reg <= cfg_data[HW-1:0];
                default:    ;
            endcase
        end
    end

    // position counters; frame restarts on a mapped write or last result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ix_reg   <= '0;
            iy_reg   <= '0;
            lead_reg <= '0;
            mx_reg   <= '0;
            my_reg   <= '0;
        end
        else if (cfg_hit || (take && last_now))
        begin
            ix_reg   <= '0;
            iy_reg   <= '0;
            lead_reg <= '0;
            mx_reg   <= '0;
            my_reg   <= '0;
        end
        else if (take)
        begin
            if (ix_reg == w_last)
            begin
                ix_reg <= '0;
                if (in_frame)
                begin
                    iy_reg <= iy_reg + HW'(1);
                end
            end
            else
            begin
                ix_reg <= ix_reg + XW'(1);
            end

            if (m_on)
            begin
                if (mx_reg == w_last)
                begin
                    mx_reg <= '0;
                    my_reg <= my_reg + YW'(1);
                end
                else
                begin
                    mx_reg <= mx_reg + XW'(1);
                end
            end
            else
            begin
                lead_reg <= lead_reg + RW'(1);
            end
        end
    end

    // stage 1 -> 2 control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_vld_reg  <= 1'b0;
            s2_out_reg  <= 1'b0;
            s2_last_reg <= 1'b0;
        end
        else if (go)
        begin
            s2_vld_reg  <= take && m_on;
            s2_out_reg  <= take && produce;
            s2_last_reg <= take && last_now;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            s2_x_reg <= mx_reg;
            s2_y_reg <= my_reg;
        end
    end

    // horizontal chain: cell i holds the pixel i requests back
    assign hwin.x   = s2_x_reg;
    assign hwin.rem = w_last - s2_x_reg;
    assign hwin.rad = r_eff;
    assign hchain[0] = pix_new;

    for (genvar i = 0; i < HCELLS; i++)
    begin : g_hcell
        mbd_hcell u_hcell (
            .clk   (clk),
            .shift (take),
            .din   (hchain[i]),
            .idx   (TW'(i)),
            .win   (hwin),
            .dout  (hchain[i+1]),
            .gated (hgated[i])
        );
    end

    always_comb
    begin
        hor_or = '0;
        for (int i = 0; i < HCELLS; i++)
        begin
            hor_or = hor_or | hgated[i];
        end
    end

    // vertical clip: tap t is row my-t; keep t in [my-(h-1), min(2r, my)]
    always_comb
    begin
        two_r   = TW'(r_eff) << 1;
        vwin.hi = (s2_y_reg < YW'(two_r)) ? s2_y_reg[TW-1:0] : two_r;
        lo_diff = s2_y_reg - YW'(h_last);
        if (s2_y_reg > YW'(h_last))
        begin
            vwin.lo = (lo_diff > YW'({TW{1'b1}})) ? {TW{1'b1}} : lo_diff[TW-1:0];
        end
        else
        begin
            vwin.lo = '0;
        end
    end

    // stage 2 -> 3
    assign adv    = go && s2_vld_reg;
    assign bypass = w_eff == XW'(1);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            hor_reg    <= hor_or;
            s3_win_reg <= vwin;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_out_reg  <= 1'b0;
            s3_last_reg <= 1'b0;
        end
        else if (go)
        begin
            s3_out_reg  <= s2_vld_reg && s2_out_reg;
            s3_last_reg <= s2_vld_reg && s2_last_reg;
        end
    end

    // shared line pointer, wraps at width-1
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ptr_reg <= '0;
        end
        else if (cfg_hit)
        begin
            ptr_reg <= '0;
        end
        else if (adv && !bypass)
        begin
            if (XW'(ptr_reg) == w_eff - XW'(2))
            begin
                ptr_reg <= '0;
            end
            else
            begin
                ptr_reg <= ptr_reg + PTR_W'(1);
            end
        end
    end

    // vertical chain: cell c outputs the horizontal OR c+1 rows up
    assign vchain[0] = hor_reg;

    for (genvar c = 0; c < VCELLS; c++)
    begin : g_vcell
        mbd_vcell u_vcell (
            .clk    (clk),
            .adv    (adv),
            .bypass (bypass),
            .ptr    (ptr_reg),
            .din    (vchain[c]),
            .idx    (TW'(c + 1)),
            .win    (s3_win_reg),
            .dout   (vchain[c+1]),
            .gated  (vgated[c])
        );
    end

    always_comb
    begin
        ver_or = (s3_win_reg.lo == '0) ? hor_reg : '0;
        for (int c = 0; c < VCELLS; c++)
        begin
            ver_or = ver_or | vgated[c];
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (go)
        begin
            out_valid_reg <= s3_out_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (go && s3_out_reg)
        begin
            mask_out_reg   <= ver_or;
            frame_last_reg <= s3_last_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign mask_out   = mask_out_reg;
    assign frame_last = frame_last_reg;

    // checks
    a_lead_bound: assert property (@(posedge clk) disable iff (!rst_n)
        lead_reg <= r_eff)
        else $error("lead count passed the radius");

    a_col_bound: assert property (@(posedge clk) disable iff (!rst_n)
        mx_reg < w_eff)
        else $error("center column outside the row");

    a_ptr_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (w_eff > XW'(1)) |-> (XW'(ptr_reg) < w_last))
        else $error("line pointer beyond row length");

    a_result_lands: assert property (@(posedge clk) disable iff (!rst_n)
        (go && s3_out_reg) |=> out_valid_reg)
        else $error("result lost between vertical stage and output");

endmodule

// File: test/mask_box_dilation_tb.sv
// Self-checking testbench for the streaming square OR-dilation of a flag mask.
`timescale 1ns / 100ps

module mask_box_dilation_tb;
    import mbd_pkg::*;

    localparam int HALF_PERIOD   = 4;
    localparam int RAW_CELLS     = 2 * MAX_RADIUS + 1;
    // horizontal ORs kept for the vertical pass: 2r full rows plus r+1 pixels
    localparam int HOR_DEPTH     = 2 * MAX_RADIUS * MAX_WIDTH + MAX_RADIUS + 1;
    localparam int RANDOM_ITEMS  = 1000;
    localparam int PRINT_CAP     = 40;

    // index 3 is not mapped; a write there must leave the frame alone
    localparam reg_idx_t REG_SPARE = 2'd3;

    typedef struct packed {
        logic [PIX_W-1:0] mask;
        logic             last;
    } dil_result_t;

    typedef enum int {
        STALL_NONE,
        STALL_LIGHT,
        STALL_HEAVY,
        STALL_PERIODIC
    } stall_mode_t;

    logic             clk        = 1'b0;
    logic             rst_n      = 1'b0;
    logic             cfg_we     = 1'b0;
    reg_idx_t         cfg_idx    = REG_RADIUS;
    logic [CFG_W-1:0] cfg_data   = '0;
    logic             in_valid   = 1'b0;
    logic             in_stall;
    logic [PIX_W-1:0] mask_in    = '0;
    logic             drain      = 1'b0;
    logic             out_valid;
    logic             out_stall  = 1'b0;
    logic [PIX_W-1:0] mask_out;
    logic             frame_last;

    // predictor copy of the programmed registers (reset values)
    logic [4:0]       radius_reg = 5'd1;
    logic [11:0]      width_reg  = 12'd2048;
    logic [15:0]      height_reg = 16'd2048;

    // predictor state
    int unsigned      pix_index  = 0;
    logic [PIX_W-1:0] raw_cells [RAW_CELLS];
    logic [PIX_W-1:0] hor_or    [HOR_DEPTH];

    dil_result_t      dilated_q [$];
    dil_result_t      want;
    int               mismatch_count = 0;
    int               items_sent     = 0;
    int               burst_left     = 0;

    stall_mode_t      stall_mode = STALL_NONE;
    int               stall_hold = 0;

    mask_box_dilation i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_idx    (cfg_idx),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .mask_in    (mask_in),
        .drain      (drain),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .mask_out   (mask_out),
        .frame_last (frame_last)
    );

    always #HALF_PERIOD clk = ~clk;

    // ------------------------------------------------------------------
    // Effective geometry: oversized values clip, zero sizes act as 1.
    // ------------------------------------------------------------------
    function automatic int unsigned clip_radius();
        return (radius_reg > MAX_RADIUS) ? MAX_RADIUS : radius_reg;
    endfunction

    function automatic int unsigned clip_width();
        if (width_reg == 0)
        begin
            return 1;
        end
        return (width_reg > MAX_WIDTH) ? MAX_WIDTH : width_reg;
    endfunction

    function automatic int unsigned clip_height();
        return (height_reg == 0) ? 1 : height_reg;
    endfunction

    // ------------------------------------------------------------------
    // Dilation predictor, run once per accepted request. Separable: the
    // pixel whose right neighbors just completed gets its horizontal OR,
    // then the pixel r rows plus r columns back gets the vertical OR of
    // the stored horizontal ORs and becomes the expected result.
    // ------------------------------------------------------------------
    function automatic void dilate_predict(input logic [PIX_W-1:0] mask, input logic drn);
        int unsigned r, w, h, n, lat, j, m, k, y, x, lo, hi, idx;
        logic [PIX_W-1:0] acc;
        logic last;
        dil_result_t res;
        r    = clip_radius();
        w    = clip_width();
        h    = clip_height();
        n    = w * h;
        lat  = r * w + r;
        j    = pix_index;
        last = 1'b0;

        // a drain at frame start is dropped without a trace
        if (j == 0 && drn)
        begin
            return;
        end

        // inside the frame a drain counts as a clean pixel; past the frame
        // every request is a flush whatever its drain bit says
        if (j < n)
        begin
            raw_cells[j % RAW_CELLS] = drn ? '0 : mask;
        end

        if (j >= r && j - r < n)
        begin
            m   = j - r;
            y   = m / w;
            x   = m % w;
            lo  = (x >= r) ? x - r : 0;
            hi  = (x + r < w) ? x + r : w - 1;
            acc = '0;
            for (idx = lo; idx <= hi; idx++)
            begin
                acc |= raw_cells[(y * w + idx) % RAW_CELLS];
            end
            hor_or[m % HOR_DEPTH] = acc;
        end

        if (j >= lat && j - lat < n)
        begin
            k   = j - lat;
            y   = k / w;
            x   = k % w;
            lo  = (y >= r) ? y - r : 0;
            hi  = (y + r < h) ? y + r : h - 1;
            acc = '0;
            for (idx = lo; idx <= hi; idx++)
            begin
                acc |= hor_or[(idx * w + x) % HOR_DEPTH];
            end
            last      = (k == n - 1);
            res.mask  = acc;
            res.last  = last;
            dilated_q = {dilated_q, res};
        end

        // the frame restarts right after its last result
        pix_index = last ? 0 : j + 1;
    endfunction

    // ------------------------------------------------------------------
    // Register write; only called while the block is idle.
    // ------------------------------------------------------------------
    task automatic write_reg(input reg_idx_t idx, input logic [CFG_W-1:0] value);
        @(negedge clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= value;
        @(posedge clk);
        case (idx)
            REG_RADIUS: radius_reg = value[4:0];
            REG_WIDTH:  width_reg  = value[11:0];
            REG_HEIGHT: height_reg = value;
            default:    ;
        endcase
        if (idx != REG_SPARE)
        begin
            pix_index = 0;
        end
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // One request on the input channel. The sender runs in bursts; at the
    // start of each burst it may idle with junk on the bus.
    // ------------------------------------------------------------------
    task automatic send_item(input logic [PIX_W-1:0] mask, input logic drn);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = ($urandom_range(4) == 0) ? $urandom_range(100, 300)
                                                  : $urandom_range(1, 24);
            gap = $urandom_range(0, 5);
            repeat (gap)
            begin
                @(negedge clk);
                in_valid <= 1'b0;
                mask_in  <= PIX_W'($urandom);
                drain    <= 1'($urandom_range(1));
            end
        end
        burst_left--;
        @(negedge clk);
        in_valid <= 1'b1;
        mask_in  <= mask;
        drain    <= drn;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
        items_sent++;
        dilate_predict(mask, drn);
    endtask

    // Stop sending and wait until every expected result is out, then let
    // the block run on idle before the task returns.
    task automatic settle_block();
        @(negedge clk);
        in_valid <= 1'b0;
        while (dilated_q.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (8) @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // A full frame at the current geometry followed by its flush.
    // flag_pct sets how often a pixel carries flags; noisy mixes in drains
    // inside the frame, pixels at flush positions and surplus drains.
    // ------------------------------------------------------------------
    task automatic send_frame(input int flag_pct, input bit noisy);
        int unsigned n, flush;
        int extra;
        n     = clip_width() * clip_height();
        flush = clip_radius() * clip_width() + clip_radius();
        for (int unsigned p = 0; p < n; p++)
        begin
            // never a drain on the first pixel: it would be dropped and
            // shift the whole frame
            if (noisy && p != 0 && $urandom_range(49) == 0)
            begin
                send_item(PIX_W'($urandom), 1'b1);
            end
            else
            begin
                send_item(($urandom_range(99) < flag_pct) ? PIX_W'($urandom) : PIX_W'(0),
                          1'b0);
            end
        end
        for (int unsigned p = 0; p < flush; p++)
        begin
            send_item(PIX_W'($urandom), !(noisy && $urandom_range(9) == 0));
        end
        if (noisy)
        begin
            extra = $urandom_range(0, 2);
            repeat (extra) send_item(PIX_W'($urandom), 1'b1);
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // 4x3 frame at radius 1: corner and edge clipping, all-ones and single
    // bit flags, a drain inside the frame, a pixel at a flush position, and
    // drains with nothing pending. Then a short pass-through at radius 0.
    task automatic test_directed();
        logic [PIX_W-1:0] pix [12];
        pix = '{8'hFF, 8'h00, 8'h00, 8'h01,
                8'h00, 8'hFF, 8'h80, 8'h00,
                8'h00, 8'h55, 8'hAA, 8'h00};
        write_reg(REG_RADIUS, 16'd1);
        write_reg(REG_WIDTH, 16'd4);
        write_reg(REG_HEIGHT, 16'd3);
        send_item(8'hFF, 1'b1);             // dropped, frame not started
        for (int i = 0; i < 12; i++)
        begin
            send_item(pix[i], i == 5);      // pixel 5 is a drain: counts as clean
        end
        send_item(8'h00, 1'b1);
        send_item(8'h3C, 1'b0);             // past the frame: taken as flush
        repeat (3) send_item(8'h00, 1'b1);
        send_item(8'hFF, 1'b1);             // surplus drain, no result
        settle_block();

        write_reg(REG_RADIUS, 16'd0);
        write_reg(REG_WIDTH, 16'd2);
        write_reg(REG_HEIGHT, 16'd1);
        send_item(8'h00, 1'b0);
        send_item(8'hFF, 1'b0);
        settle_block();
    endtask

    // zero sizes, clipped radius and clipped width, unmapped register
    task automatic test_degenerate_sizes();
        write_reg(REG_RADIUS, 16'd0);
        write_reg(REG_WIDTH, 16'd0);
        write_reg(REG_HEIGHT, 16'd0);
        send_frame(50, 1'b0);
        settle_block();

        write_reg(REG_RADIUS, 16'd31);      // acts as the maximum radius
        write_reg(REG_SPARE, 16'hFFFF);
        send_frame(100, 1'b0);
        settle_block();

        write_reg(REG_RADIUS, 16'd0);
        write_reg(REG_WIDTH, 16'hFFFF);     // 12-bit field 4095, clips to max
        write_reg(REG_HEIGHT, 16'd1);
        // head of the row only; the next register write restarts the frame
        for (int i = 0; i < 40; i++)
        begin
            send_item(PIX_W'($urandom), 1'b0);
        end
        settle_block();

        write_reg(REG_RADIUS, 16'd17);
        write_reg(REG_WIDTH, 16'd5);
        write_reg(REG_HEIGHT, 16'd2);
        send_frame(20, 1'b1);
        settle_block();
    endtask

    // random geometry, back-to-back frames, junk in unused register bits
    task automatic test_random_frames();
        int base;
        int unsigned rad, wid, hgt, w_next;
        logic [CFG_W-1:0] junk;
        bit wr_rad, wr_wid;
        base = items_sent;
        while (items_sent - base < RANDOM_ITEMS)
        begin
            case ($urandom_range(9))
                0, 1, 2, 3, 4, 5: rad = $urandom_range(0, 3);
                6, 7, 8:          rad = $urandom_range(4, 8);
                default:          rad = $urandom_range(9, 31);
            endcase
            case ($urandom_range(19))
                0:                wid = 0;
                1, 2, 3, 4, 5:    wid = $urandom_range(17, 48);
                default:          wid = $urandom_range(1, 16);
            endcase
            hgt    = $urandom_range(0, 10);
            wr_rad = $urandom_range(2) != 0;
            wr_wid = $urandom_range(2) != 0;

            // wide rows only with a small radius, so the flush stays short
            w_next = wr_wid ? wid : width_reg;
            if (w_next > 16)
            begin
                rad    = rad % 4;
                wr_rad = 1'b1;
            end

            if (wr_rad)
            begin
                junk = 16'($urandom);
                write_reg(REG_RADIUS, {junk[CFG_W-1:5], rad[4:0]});
            end
            if (wr_wid)
            begin
                junk = 16'($urandom);
                write_reg(REG_WIDTH, {junk[CFG_W-1:12], wid[11:0]});
            end
            if ($urandom_range(2) != 0)
            begin
                write_reg(REG_HEIGHT, hgt[15:0]);
            end
            if ($urandom_range(15) == 0)
            begin
                write_reg(REG_SPARE, 16'($urandom));
            end
            repeat ($urandom_range(1, 2)) send_frame($urandom_range(5, 40), 1'b1);
            settle_block();
        end
    endtask

    // maximum radius on a tall narrow frame fills every row tap, then the
    // top rows of the tallest frame at pass-through
    task automatic test_large_frames();
        write_reg(REG_RADIUS, 16'd16);
        write_reg(REG_WIDTH, 16'd3);
        write_reg(REG_HEIGHT, 16'd40);
        send_frame(3, 1'b0);
        settle_block();

        write_reg(REG_RADIUS, 16'd0);
        write_reg(REG_WIDTH, 16'd1);
        write_reg(REG_HEIGHT, 16'hFFFF);
        for (int i = 0; i < 20; i++)
        begin
            send_item(PIX_W'($urandom), 1'b0);
        end
        settle_block();
    endtask

    // ------------------------------------------------------------------
    // Sink: stall pattern changes mode at random intervals.
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (stall_hold == 0)
        begin
            stall_mode = stall_mode_t'($urandom_range(0, 3));
            stall_hold = $urandom_range(40, 400);
        end
        else
        begin
            stall_hold--;
        end
        case (stall_mode)
            STALL_NONE:  out_stall <= 1'b0;
            STALL_LIGHT: out_stall <= ($urandom_range(3) == 0);
            STALL_HEAVY: out_stall <= ($urandom_range(9) < 6);
            default:     out_stall <= (stall_hold % 4) != 0;
        endcase
    end

    // ------------------------------------------------------------------
    // Result check against the oldest expectation.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (dilated_q.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= PRINT_CAP)
                begin
                    $display("%0t: unexpected result mask_out=%02h frame_last=%0b",
                             $time, mask_out, frame_last);
                end
            end
            else
            begin
                want = dilated_q.pop_front();
                if (mask_out !== want.mask)
                begin
                    mismatch_count++;
                    if (mismatch_count <= PRINT_CAP)
                    begin
                        $display("%0t: mask_out expected %02h actual %02h",
                                 $time, want.mask, mask_out);
                    end
                end
                if (frame_last !== want.last)
                begin
                    mismatch_count++;
                    if (mismatch_count <= PRINT_CAP)
                    begin
                        $display("%0t: frame_last expected %0b actual %0b",
                                 $time, want.last, frame_last);
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial
    begin
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        repeat (3) @(posedge clk);

        test_directed();
        test_degenerate_sizes();
        test_random_frames();
        test_large_frames();

        repeat (20) @(posedge clk);
        if (mismatch_count == 0 && dilated_q.size() == 0)
        begin
            $display("CHECK OK");
        end
        else
        begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    // watchdog
    initial
    begin
        #2_000_000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
